// ----- hw/rtl/mnmf_pkg.sv -----
// ----------------------------------------------------------------------------
// mnmf_pkg
// Shared types and constants of the masked neighbor mean filter.
// ----------------------------------------------------------------------------
package mnmf_pkg;

    localparam int MNMF_MAX_WIDTH = 2048;

    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int SUM_W      = 11;
    localparam int DEN_W      = 4;
    localparam int SLOT_W     = 3;
    localparam int STEP_W     = 4;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 12'd480;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // ring fetch slots: center, right, below-left, below, below-right
    localparam logic [SLOT_W-1:0] SLOT_CTR = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_E   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_SW  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_S   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_SE  = 3'd4;

    localparam logic [STEP_W-1:0] DIV_LAST = 4'(SUM_W - 1);

    // neighbor order: ul, up, ur, left, right, below-left, below, below-right
    localparam logic [7:0] MASK_ALL    = 8'b1111_1111;
    localparam logic [7:0] MASK_TOP    = 8'b0001_1111;
    localparam logic [7:0] MASK_CORNER = 8'b0000_1011;

    typedef struct packed {
        logic              wr_px;
        logic              base_ld;
        logic              fetch;
        logic [SLOT_W-1:0] slot;
        logic              div_start;
        logic              div_step;
        logic              wb;
    } t_cmd;

    typedef struct packed {
        logic pend_nz;
        logic pend_over;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/mnmf_if.sv -----
// ----------------------------------------------------------------------------
// mnmf_if
// Stream and configuration channels of the masked neighbor mean filter.
// ----------------------------------------------------------------------------
interface mnmf_px_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    modport source (output valid, op, blue_in, green_in, red_in, input ready);
    modport sink   (input valid, op, blue_in, green_in, red_in, output ready);
endinterface

interface mnmf_px_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_last;
    modport source (output valid, blue_out, green_out, red_out, frame_last, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, frame_last, output ready);
endinterface

interface mnmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/mnmf_div.sv -----
// ----------------------------------------------------------------------------
// mnmf_div
// Restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module mnmf_div import mnmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic             i_step,
    input  logic [SUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [CH_W-1:0]  o_quo
);
    logic [SUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    assign rem_sh = {r_rem, r_num[SUM_W-1]};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_step) begin
            r_num <= {r_num[SUM_W-2:0], take};
            r_rem <= take ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
        end
    end

    assign o_quo = r_num[CH_W-1:0];
endmodule

// ----- hw/rtl/mnmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mnmf_ctrl
// Sequencer: accept, ring fetch, divide, write back.
// ----------------------------------------------------------------------------
module mnmf_ctrl import mnmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHK   = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_DRAIN = 8'b0001_0000,
        S_SUM   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_WB    = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [STEP_W-1:0]  r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_step  = r_step;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.slot = r_slot;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op == OP_PIXEL) begin
                        o_cmd.wr_px = 1'b1;
                        n_state = S_CHK;
                    end else if (i_sts.pend_nz) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_CHK: n_state = i_sts.pend_over ? S_PREP : S_IDLE;
            S_PREP: begin
                o_cmd.base_ld = 1'b1;
                n_slot  = SLOT_CTR;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (r_slot == SLOT_SE) begin
                    n_state = S_DRAIN;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            S_DRAIN: n_state = S_SUM;
            S_SUM: begin
                o_cmd.div_start = 1'b1;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = S_WB;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_WB: begin
                if (i_sts.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- hw/rtl/mnmf_dp.sv -----
// ----------------------------------------------------------------------------
// mnmf_dp
// Datapath: pixel ring, filtered row, neighbor sums, dividers, output word.
// ----------------------------------------------------------------------------
module mnmf_dp import mnmf_pkg::*; #(
    parameter int MAX_WIDTH = MNMF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [CH_W-1:0]       i_blue,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_red,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CH_W-1:0]       o_blue,
    output logic [CH_W-1:0]       o_green,
    output logic [CH_W-1:0]       o_red,
    output logic                  o_frame_last
);
    localparam int RING = 2 * MAX_WIDTH;
    localparam int AW   = $clog2(RING);
    localparam int PW   = $clog2(RING + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;
    localparam logic [EW-1:0] MAXW  = EW'(MAX_WIDTH);
    localparam logic [PW:0]   RINGV = (PW+1)'(RING);
    localparam logic [CW-1:0] LASTC = CW'(MAX_WIDTH - 1);

    logic [PIX_W-1:0] ring [RING];
    logic [PIX_W-1:0] rowm [MAX_WIDTH];

    logic [CFG_DATA_W-1:0] r_width, r_height;
    logic [AW-1:0]         r_wptr, r_base;
    logic [PW-1:0]         r_pend;
    logic [CW-1:0]         r_ocol;
    logic [ROW_W-1:0]      r_orow;
    logic [PIX_W-1:0]      r_left, r_ul;
    logic [PIX_W-1:0]      r_ring_q, r_row_q;
    logic [PIX_W-1:0]      r_ctr, r_e, r_sw, r_s, r_se, r_up, r_ur;
    logic                  r_fact, r_fv, r_pass;
    logic [SLOT_W-1:0]     r_fk;
    logic                  r_out_valid;

    logic [EW-1:0]    w_raw, w_eff, pend_x;
    logic [ROW_W-1:0] h_eff;
    logic             last_col, last_row;
    logic [PW:0]      wp_x, pd_x, base_n, off_x, addr_sum, addr_m;
    logic [AW-1:0]    ring_addr;
    logic [CW-1:0]    col_nx, row_raddr;
    logic             in_rng;
    logic [PIX_W-1:0] nbr [8];
    logic [7:0]       mask;
    logic [SUM_W-1:0] sum [3];
    logic [DEN_W-1:0] den [3];
    logic [CH_W-1:0]  quo [3];
    logic [PIX_W-1:0] res;

    assign w_raw  = EW'(r_width);
    assign w_eff  = (w_raw < EW'(2)) ? EW'(2) : ((w_raw > MAXW) ? MAXW : w_raw);
    assign h_eff  = (r_height < 12'd2) ? 12'd2 : r_height;
    assign pend_x = EW'(r_pend);

    assign last_col = EW'(r_ocol) >= (w_eff - EW'(1));
    assign last_row = r_orow >= (h_eff - 12'd1);

    assign o_sts.pend_nz   = r_pend != '0;
    assign o_sts.pend_over = pend_x > (w_eff + EW'(1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign wp_x   = (PW+1)'(r_wptr);
    assign pd_x   = (PW+1)'(r_pend);
    assign base_n = (wp_x >= pd_x) ? (wp_x - pd_x) : (wp_x + RINGV - pd_x);

    always_comb begin
        case (i_cmd.slot)
            SLOT_CTR: off_x = '0;
            SLOT_E:   off_x = (PW+1)'(1);
            SLOT_SW:  off_x = (PW+1)'(w_eff - EW'(1));
            SLOT_S:   off_x = (PW+1)'(w_eff);
            default:  off_x = (PW+1)'(w_eff + EW'(1));
        endcase
    end

    assign addr_sum  = (PW+1)'(r_base) + off_x;
    assign addr_m    = (addr_sum >= RINGV) ? (addr_sum - RINGV) : addr_sum;
    assign ring_addr = addr_m[AW-1:0];
    assign in_rng    = off_x < pd_x;
    assign col_nx    = (r_ocol == LASTC) ? '0 : (r_ocol + CW'(1));
    assign row_raddr = (i_cmd.slot == SLOT_E) ? col_nx : r_ocol;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_px) ring[r_wptr] <= {i_red, i_green, i_blue};
        if (i_cmd.fetch) r_ring_q <= ring[ring_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) rowm[r_ocol] <= res;
        if (i_cmd.fetch) r_row_q <= rowm[row_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_fk <= i_cmd.slot;
        r_fv <= in_rng;
        if (i_cmd.base_ld) r_base <= base_n[AW-1:0];
        if (r_fact) begin
            case (r_fk)
                SLOT_CTR: begin
                    r_ctr <= r_fv ? r_ring_q : '0;
                    r_up  <= r_row_q;
                end
                SLOT_E: begin
                    r_e  <= r_fv ? r_ring_q : '0;
                    r_ur <= r_row_q;
                end
                SLOT_SW: r_sw <= r_fv ? r_ring_q : '0;
                SLOT_S:  r_s  <= r_fv ? r_ring_q : '0;
                default: r_se <= r_fv ? r_ring_q : '0;
            endcase
        end
        if (i_cmd.div_start) r_pass <= last_row || last_col ||
                                       (r_orow != '0 && r_ocol == '0);
    end

    assign nbr[0] = r_ul;
    assign nbr[1] = r_up;
    assign nbr[2] = r_ur;
    assign nbr[3] = r_left;
    assign nbr[4] = r_e;
    assign nbr[5] = r_sw;
    assign nbr[6] = r_s;
    assign nbr[7] = r_se;

    assign mask = (r_orow != '0) ? MASK_ALL : ((r_ocol == '0) ? MASK_CORNER : MASK_TOP);

    always_comb begin
        logic [CH_W-1:0]  v;
        logic [DEN_W-1:0] nz;
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            nz      = '0;
            for (int k = 0; k < 8; k++) begin
                v = nbr[k][CH_W*ch +: CH_W];
                if (mask[7-k]) begin
                    sum[ch] = sum[ch] + SUM_W'(v);
                    if (v != '0) nz = nz + DEN_W'(1);
                end
            end
            den[ch] = nz + DEN_W'(1);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        mnmf_div u_div (
            .i_clk   (i_clk),
            .i_start (i_cmd.div_start),
            .i_step  (i_cmd.div_step),
            .i_num   (sum[g]),
            .i_den   (den[g]),
            .o_quo   (quo[g])
        );
    end

    assign res = r_pass ? r_ctr : {quo[2], quo[1], quo[0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            {o_red, o_green, o_blue} <= res;
            o_frame_last <= last_row && last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_pend      <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_left      <= '0;
            r_ul        <= '0;
            r_fact      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fact <= i_cmd.fetch;
            if (i_cmd.wr_px) begin
                r_wptr <= (r_wptr == AW'(RING - 1)) ? '0 : (r_wptr + AW'(1));
                if (r_pend != PW'(RING)) r_pend <= r_pend + PW'(1);
            end
            if (i_cmd.wb) begin
                r_pend <= r_pend - PW'(1);
                r_ul   <= r_up;
                r_left <= res;
                if (last_col) begin
                    r_ocol <= '0;
                    r_orow <= last_row ? '0 : (r_orow + 12'd1);
                end else begin
                    r_ocol <= r_ocol + CW'(1);
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- hw/rtl/masked_neighbor_mean_filter_unit.sv -----
// ----------------------------------------------------------------------------
// masked_neighbor_mean_filter_unit
// In-place masked neighbor mean filter over a raster BGR pixel stream.
// ----------------------------------------------------------------------------
// Channels: i_px takes words (op 0 = pixel, op 1 = flush tick), o_px
// delivers filtered words with frame_last on the frame's final pixel, i_cfg
// writes frame_width (index 0) and frame_height (index 1); it is always
// ready, and the user must write it only while the block is idle (not
// enforced by the block). A result belongs to the pixel width+1 pixels
// earlier; flush ticks drain the pending pixels one at a time.
// A pixel that releases no result only passes the check state. A word that
// releases a result runs five reads through the pixel ring's read port and
// an 11-step restoring divide per channel; no new word is accepted until it
// is written back. o_px.valid is registered from the write-back.
// Results wait in an output register; while it is full the next word is
// still accepted, and the sequencer holds in write-back until o_px.ready.
// Reset (synchronous, active low) clears positions, counters and the left
// and upper-left pixels and restores width 640, height 480. The row and
// ring memories are not cleared.
// ----------------------------------------------------------------------------
module masked_neighbor_mean_filter_unit import mnmf_pkg::*; #(
    parameter int MAX_WIDTH = MNMF_MAX_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mnmf_px_in_if.sink    i_px,
    mnmf_px_out_if.source o_px,
    mnmf_cfg_if.sink      i_cfg
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_px.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    mnmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_px.valid),
        .i_op    (i_px.op),
        .i_sts   (sts),
        .o_ready (in_ready),
        .o_cmd   (cmd)
    );

    mnmf_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_blue       (i_px.blue_in),
        .i_green      (i_px.green_in),
        .i_red        (i_px.red_in),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_px.ready),
        .o_out_valid  (o_px.valid),
        .o_blue       (o_px.blue_out),
        .o_green      (o_px.green_out),
        .o_red        (o_px.red_out),
        .o_frame_last (o_px.frame_last)
    );

    a_wb_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wb |-> (!o_px.valid || o_px.ready))
        else $error("write-back over an untaken result");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_px.valid) |-> $past(cmd.wb))
        else $error("result valid without write-back");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.fetch || cmd.div_step || cmd.div_start) |-> !i_px.ready)
        else $error("input ready while a pixel is in flight");
endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for masked_neighbor_mean_filter_unit: raster frames of
// varied sizes with random pixel content and flush ticks go in, every filtered
// word that comes out is checked against an in-bench prediction of the filter.
// ----------------------------------------------------------------------------
module tb_top import mnmf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W  = MNMF_MAX_WIDTH;
    localparam int RING_D = 2 * MNMF_MAX_WIDTH;

    typedef struct {
        logic       op;
        logic [7:0] b, g, r;
    } t_word;

    typedef struct {
        logic [7:0] b, g, r;
        logic       last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mnmf_px_in_if  px_in ();
    mnmf_px_out_if px_out ();
    mnmf_cfg_if    cfg ();

    masked_neighbor_mean_filter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (px_in.sink),
        .o_px    (px_out.source),
        .i_cfg   (cfg.sink)
    );

    always #1 i_clk = ~i_clk;

    // filter state as the bench sees it
    logic [23:0] filt_row [MAX_W];
    logic [23:0] ring [RING_D];
    logic [23:0] left_px, ul_px;
    int unsigned in_col, in_row, out_col, out_row, wr_ptr, n_pend;
    logic [11:0] cfg_w = WIDTH_RST, cfg_h = HEIGHT_RST;

    t_word   word_q [$];
    t_result filtered_q [$];
    int      n_fail = 0;

    function automatic int unsigned eff_w(logic [11:0] v);
        if (v < 2) return 2;
        if (v > MAX_W) return MAX_W;
        return v;
    endfunction

    function automatic int unsigned eff_h(logic [11:0] v);
        return (v < 2) ? 2 : v;
    endfunction

    function automatic logic [23:0] ring_at(int unsigned off);
        int unsigned base;
        if (off >= n_pend) return 24'd0;
        base = (wr_ptr + RING_D - n_pend) % RING_D;
        return ring[(base + off) % RING_D];
    endfunction

    function automatic logic [23:0] masked_mean(logic [23:0] nb [8], int cnt);
        logic [23:0] res;
        int unsigned sum, nz;
        logic [7:0] v;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            nz  = 0;
            for (int k = 0; k < cnt; k++) begin
                v = nb[k][8*ch +: 8];
                sum += v;
                if (v != 0) nz++;
            end
            res[8*ch +: 8] = 8'(sum / (nz + 1));
        end
        return res;
    endfunction

    function automatic void release_pixel();
        int unsigned w, h, r, c;
        logic [23:0] v;
        logic [23:0] nb [8];
        logic last_row, last_col;
        t_result res;
        w = eff_w(cfg_w);
        h = eff_h(cfg_h);
        r = out_row;
        c = out_col % MAX_W;
        v = ring_at(0);
        last_row = (r >= h - 1);
        last_col = (c >= w - 1);
        for (int k = 0; k < 8; k++) nb[k] = '0;
        if (!last_row && !last_col) begin
            if (r == 0 && c == 0) begin
                nb[0] = ring_at(1);
                nb[1] = ring_at(w);
                nb[2] = ring_at(w + 1);
                v = masked_mean(nb, 3);
            end else if (r == 0) begin
                nb[0] = left_px;
                nb[1] = ring_at(1);
                nb[2] = ring_at(w - 1);
                nb[3] = ring_at(w);
                nb[4] = ring_at(w + 1);
                v = masked_mean(nb, 5);
            end else if (c != 0) begin
                nb[0] = ul_px;
                nb[1] = filt_row[c];
                nb[2] = filt_row[(c + 1) % MAX_W];
                nb[3] = left_px;
                nb[4] = ring_at(1);
                nb[5] = ring_at(w - 1);
                nb[6] = ring_at(w);
                nb[7] = ring_at(w + 1);
                v = masked_mean(nb, 8);
            end
        end
        ul_px       = filt_row[c];
        filt_row[c] = v;
        left_px     = v;
        res.b    = v[7:0];
        res.g    = v[15:8];
        res.r    = v[23:16];
        res.last = last_row && last_col;
        filtered_q.insert(filtered_q.size(), res);
        if (last_col) begin
            out_col = 0;
            out_row = last_row ? 0 : r + 1;
        end else begin
            out_col = c + 1;
        end
        n_pend--;
    endfunction

    function automatic void filter_word(t_word wd);
        int unsigned w, h;
        w = eff_w(cfg_w);
        h = eff_h(cfg_h);
        if (wd.op == OP_PIXEL) begin
            ring[wr_ptr] = {wd.r, wd.g, wd.b};
            wr_ptr = (wr_ptr + 1) % RING_D;
            if (n_pend < RING_D) n_pend++;
            if (in_col >= w - 1) begin
                in_col = 0;
                in_row = (in_row >= h - 1) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
            if (n_pend > w + 1) release_pixel();
        end else if (n_pend > 0) begin
            release_pixel();
        end
    endfunction

    // sender
    logic  tx_busy = 1'b0;
    int    tx_gap = 0;
    bit    tx_burst = 1'b0;
    t_word tx_cur;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_busy = 1'b0;
        end else begin
            if (tx_busy && px_in.ready) begin
                filter_word(tx_cur);
                tx_busy = 1'b0;
                if ($urandom_range(0, 63) == 0) tx_burst = ~tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 16);
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (word_q.size() > 0) begin
                    tx_cur = word_q.pop_front();
                    tx_busy = 1'b1;
                    px_in.op       <= tx_cur.op;
                    px_in.blue_in  <= tx_cur.b;
                    px_in.green_in <= tx_cur.g;
                    px_in.red_in   <= tx_cur.r;
                end
            end
        end
        px_in.valid <= tx_busy;
    end

    // long receiver hold-off
    bit hold_req = 1'b0, hold_seen = 1'b0;
    int hold_cnt = 0;

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= 600;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // receiver and checker
    int      rx_gap = 0;
    bit      rx_burst = 1'b0;
    t_result exp_r;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            px_out.ready <= 1'b0;
        end else begin
            if (px_out.valid && px_out.ready) begin
                if (filtered_q.size() == 0) begin
                    $error("filtered word with none expected");
                    n_fail++;
                end else begin
                    exp_r = filtered_q.pop_front();
                    if (px_out.blue_out !== exp_r.b) begin
                        $error("blue_out: expected %0d, got %0d", exp_r.b, px_out.blue_out);
                        n_fail++;
                    end
                    if (px_out.green_out !== exp_r.g) begin
                        $error("green_out: expected %0d, got %0d", exp_r.g, px_out.green_out);
                        n_fail++;
                    end
                    if (px_out.red_out !== exp_r.r) begin
                        $error("red_out: expected %0d, got %0d", exp_r.r, px_out.red_out);
                        n_fail++;
                    end
                    if (px_out.frame_last !== exp_r.last) begin
                        $error("frame_last: expected %0d, got %0d", exp_r.last,
                               px_out.frame_last);
                        n_fail++;
                    end
                end
                if ($urandom_range(0, 31) == 0) rx_burst = ~rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, 16);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            px_out.ready <= (rx_gap == 0) && (hold_cnt == 0);
        end
    end

    // stimulus
    int unsigned gen_pend = 0, gen_w = 640, n_words = 0;

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 7))
            0, 1:    return 8'd0;
            2:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_word(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        t_word wd;
        wd.op = op;
        wd.b = b;
        wd.g = g;
        wd.r = r;
        word_q.insert(word_q.size(), wd);
        n_words++;
        if (op == OP_PIXEL) begin
            if (gen_pend < RING_D) gen_pend++;
            if (gen_pend > gen_w + 1) gen_pend--;
        end else if (gen_pend > 0) begin
            gen_pend--;
        end
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || tx_busy || filtered_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        if (idx == REG_WIDTH) cfg_w = val;
        else cfg_h = val;
    endtask

    task automatic set_size(logic [11:0] w, logic [11:0] h);
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        gen_w = eff_w(w);
    endtask

    task automatic drain();
        while (gen_pend > 0)
            push_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_frame(int flush_pct);
        int unsigned n;
        n = eff_w(cfg_w) * eff_h(cfg_h);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < flush_pct)
                push_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            push_word(OP_PIXEL, pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    initial begin
        px_in.valid = 1'b0;
        px_in.op = OP_PIXEL;
        px_in.blue_in = '0;
        px_in.green_in = '0;
        px_in.red_in = '0;
        px_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        for (int k = 0; k < MAX_W; k++) filt_row[k] = '0;
        for (int k = 0; k < RING_D; k++) ring[k] = '0;
        left_px = '0;
        ul_px = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        wr_ptr = 0;
        n_pend = 0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x3 frame with extreme channel values, flush on empty
        set_size(12'd3, 12'd3);
        push_word(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        push_word(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        push_word(OP_PIXEL, 8'd0, 8'd0, 8'd0);
        push_word(OP_PIXEL, 8'd255, 8'd0, 8'd1);
        push_word(OP_PIXEL, 8'd0, 8'd255, 8'd0);
        push_word(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        push_word(OP_PIXEL, 8'd1, 8'd128, 8'd255);
        push_word(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        push_word(OP_PIXEL, 8'd0, 8'd0, 8'd255);
        push_word(OP_PIXEL, 8'd170, 8'd85, 8'd255);
        drain();
        push_word(OP_FLUSH, 8'h00, 8'h00, 8'h00);

        // directed: width and height below range, flush before neighbors arrive
        set_size(12'd0, 12'd1);
        push_word(OP_PIXEL, 8'd200, 8'd100, 8'd50);
        push_word(OP_FLUSH, 8'd0, 8'd0, 8'd0);
        push_word(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        push_word(OP_PIXEL, 8'd9, 8'd0, 8'd255);
        push_word(OP_PIXEL, 8'd255, 8'd1, 8'd0);
        drain();

        // narrow and tall frame
        set_size(12'd1, 12'd20);
        send_frame(1);
        drain();
        wait_idle();

        // random frames
        while (n_words < 750) begin
            set_size(($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1))
                                                 : 12'($urandom_range(2, 9)),
                     ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1))
                                                 : 12'($urandom_range(2, 6)));
            if ($urandom_range(0, 7) == 0) hold_req = ~hold_req;
            repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 3) == 0 ? 15 : 0);
            drain();
        end
        hold_req = ~hold_req;
        set_size(12'd8, 12'd5);
        send_frame(0);
        drain();

        wait_idle();
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
